[hdl/skset_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared constants, request codes and the cell control bundle.
// ----------------------------------------------------------------------------
package skset_pkg;

  // Default capacity and key width.
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KEY_BITS_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COUNT_W = 9;

  // Number of match flags that one first-level OR gate combines.
  localparam int unsigned GRP_SIZE = 16;

  // Operation codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_MEMBER = 2'd2
  } req_type_e;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic cmp_en;  // register compare flags against the broadcast key
    logic ins;     // shift up from the insert position
    logic del;     // shift down from the delete position
  } cell_ctl_t;

endpackage

[hdl/skset_if.sv]
// ----------------------------------------------------------------------------
// Sorted key set channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface skset_req_if;
  logic                          valid;
  logic                          ready;
  logic [skset_pkg::REQ_W-1:0]   req_type;
  logic [skset_pkg::KEY_W-1:0]   key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface skset_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic                          set_full;
  logic [skset_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output success, output set_full, output entry_count,
                  input ready);
  modport sink   (input valid, input success, input set_full, input entry_count,
                  output ready);
endinterface

[hdl/skset_cell.sv]
// ----------------------------------------------------------------------------
// Sorted key set cell
// Holds one key slot, compares it with the broadcast key and shifts to or
// from its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skset_cell #(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned KEY_BITS = skset_pkg::KEY_BITS_DEF,
  parameter int unsigned CNT_W    = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skset_pkg::cell_ctl_t  ctl_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [KEY_BITS-1:0]   left_key_i,
  input  logic                  left_lt_i,
  input  logic [KEY_BITS-1:0]   right_key_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic                  lt_o,
  output logic                  eq_o
);
  import skset_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                lt_q, eq_q;
  logic                occ;

  // The slot holds a key when its index lies below the entry count.
  assign occ = CNT_W'(INDEX) < count_i;

  // Next slot content: keep it below the sorted position, otherwise take the
  // new key or the neighbor's key depending on the operation.
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !lt_q) begin
      key_d = left_lt_i ? key_i : left_key_i;
    end else if (ctl_i.del && !lt_q) begin
      key_d = right_key_i;
    end
  end

  // Slot storage carries no reset; only occupied slots are ever compared.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Compare flags, captured when a transaction is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      lt_q <= occ && (key_q < key_i);
      eq_q <= occ && (key_q == key_i);
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

[hdl/sorted_key_set_core.sv]
// An accepted request passes through the compare stage in the cells, the two
// registered stages of the match OR tree and the shift stage, which registers
// the response; the next request is taken only after the shift stage is done.
// A finished response waits in an output register while the next request runs.
// Reset clears the entry count to zero (empty set); key slots are not cleared.
// ----------------------------------------------------------------------------
// Sorted key set core
// A chain of cells keeps distinct keys in ascending order and serves insert,
// delete and membership requests, each returning one response.
// ----------------------------------------------------------------------------
module sorted_key_set_core #(
  parameter int unsigned CAPACITY = skset_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = skset_pkg::KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skset_req_if.sink   req_i,
  skset_rsp_if.source rsp_o
);
  import skset_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned EXT_K = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned EXT_C = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GRP,
    PH_FND,
    PH_UPD
  } phase_e;

  phase_e              phase_q;
  logic [REQ_W-1:0]    op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [NGRP-1:0]     grp_q;
  logic                found_q;
  logic [CNT_W-1:0]    count_q;
  logic                rsp_valid_q;
  logic                success_q;
  logic                full_q;
  logic [COUNT_W-1:0]  entry_count_q;

  logic [EXT_K-1:0]    in_key_ext;
  logic [KEY_BITS-1:0] in_key;
  logic [KEY_BITS-1:0] bcast_key;
  logic                req_fire;
  logic                upd_go;
  logic                do_ins, do_del, refuse, hit;
  logic [CNT_W-1:0]    count_d;
  logic [EXT_C-1:0]    count_ext;
  cell_ctl_t           ctl;

  logic [KEY_BITS-1:0]      cell_key [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [NGRP*GRP_SIZE-1:0] eq_pad;

  // Handshake and key narrowing.
  assign req_i.ready = (phase_q == PH_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_key_ext  = EXT_K'(req_i.key);
  assign in_key      = in_key_ext[KEY_BITS-1:0];
  assign bcast_key   = (phase_q == PH_IDLE) ? in_key : key_q;

  // Decision taken once the match flag is known.
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    refuse = 1'b0;
    hit    = 1'b0;
    unique case (op_q)
      REQ_INSERT: begin
        do_ins = !found_q && (count_q < CNT_W'(CAPACITY));
        refuse = !found_q && (count_q >= CNT_W'(CAPACITY));
      end
      REQ_DELETE: begin
        do_del = found_q;
      end
      REQ_MEMBER: begin
        hit = found_q;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign upd_go = (phase_q == PH_UPD) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_del) begin
      count_d = count_q - CNT_W'(1);
    end
  end
  assign count_ext = EXT_C'(count_d);

  // Broadcast control to the cells.
  assign ctl.cmp_en = req_fire;
  assign ctl.ins    = upd_go && do_ins;
  assign ctl.del    = upd_go && do_del;

  // The chain of cells; cell 0 sees an always-less left neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] left_key, right_key;
    logic                left_lt;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skset_cell #(
      .INDEX    (i),
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_i       (bcast_key),
      .count_i     (count_q),
      .left_key_i  (left_key),
      .left_lt_i   (left_lt),
      .right_key_i (right_key),
      .key_o       (cell_key[i]),
      .lt_o        (cell_lt[i]),
      .eq_o        (eq_pad[i])
    );
  end

  // Pad the match flags to whole groups.
  if (NGRP * GRP_SIZE > CAPACITY) begin : g_pad
    assign eq_pad[NGRP*GRP_SIZE-1:CAPACITY] = '0;
  end

  // Sequencer, match OR tree, entry count and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      grp_q       <= '0;
      found_q     <= 1'b0;
      op_q        <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !upd_go) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (phase_q)
        PH_IDLE: begin
          if (req_fire) begin
            op_q    <= req_i.req_type;
            phase_q <= PH_GRP;
          end
        end
        PH_GRP: begin
          for (int g = 0; g < NGRP; g++) begin
            grp_q[g] <= |eq_pad[g*GRP_SIZE +: GRP_SIZE];
          end
          phase_q <= PH_FND;
        end
        PH_FND: begin
          found_q <= |grp_q;
          phase_q <= PH_UPD;
        end
        PH_UPD: begin
          if (upd_go) begin
            count_q     <= count_d;
            rsp_valid_q <= 1'b1;
            phase_q     <= PH_IDLE;
          end
        end
        default: begin
          phase_q <= PH_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      key_q <= in_key;
    end
    if (upd_go) begin
      success_q     <= do_ins || do_del || hit;
      full_q        <= refuse;
      entry_count_q <= count_ext[COUNT_W-1:0];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.success     = success_q;
  assign rsp_o.set_full    = full_q;
  assign rsp_o.entry_count = entry_count_q;

endmodule
